[src/btff_pkg.sv]
// shared types and constants of the boundary tag first fit allocator
`default_nettype none
package btff_pkg;

    localparam int unsigned HEAP_BYTES_DEF      = 65536;
    localparam int unsigned MIN_SPLIT_BYTES_DEF = 16;
    localparam int unsigned OFF_W               = 17;
    localparam int unsigned TAG_W               = 18;
    localparam int unsigned CFG_W               = 17;

    localparam logic [OFF_W-1:0] FIRST_BP   = 17'd16;
    localparam logic [OFF_W-1:0] MIN_FIRST  = 17'd24;
    localparam logic [OFF_W-1:0] PRO_HDR    = 17'd4;
    localparam logic [OFF_W-1:0] PRO_FTR    = 17'd8;
    localparam logic [OFF_W-1:0] FIRST_HDR  = 17'd12;
    localparam logic [TAG_W-1:0] PRO_TAG    = 18'd9;
    localparam logic [TAG_W-1:0] EPI_TAG    = 18'd1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_NOMEM  = 2'd2;

    localparam logic CFG_HEAP_LIMIT = 1'b0;
    localparam logic CFG_GROW_CHUNK = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [5:0] {
        C_IDLE, C_LOAD,
        C_INIT_W0, C_INIT_W1, C_INIT_W2, C_INIT_W3, C_INIT_W4,
        C_RD_HDR, C_BP_ADV,
        C_GROW_W0, C_GROW_W1, C_GROW_W2,
        C_RD_NEXT, C_MRG_W0, C_MRG_W1, C_RD_PFT, C_RD_PHDR, C_PM,
        C_PL_A, C_PL_B, C_PL_SA, C_PL_SB, C_PL_SC, C_PL_SD,
        C_FR_W0, C_FR_W1,
        C_ST1, C_ST2, C_EMIT
    } t_cmd;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH,
        S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_INIT4,
        S_REQ, S_FF_TEST, S_FF_CHK,
        S_GROW, S_GROW1, S_GROW2,
        S_CO_RD, S_CO_NX, S_CO_N, S_CO_M1, S_CO_PF, S_CO_PC, S_CO_PU,
        S_CO_PN, S_CO_PM1, S_CO_END,
        S_PL_RD, S_PL_CHK, S_PL_B, S_PL_SB, S_PL_SC, S_PL_SD,
        S_FR_TEST, S_FR_CHK, S_FR_W1,
        S_ST1, S_ST2, S_EMIT
    } t_state;

    typedef struct packed {
        logic is_free;
        logic ready;
        logic init_fits;
        logic req_zero;
        logic addr_zero;
        logic bp_lt_end;
        logic bp_le_addr;
        logic bp_eq_addr;
        logic rd_zero;
        logic rd_used;
        logic rd_fit;
        logic grow_ok;
        logic prev_ok;
        logic split;
        logic out_busy;
    } t_flags;

endpackage
`default_nettype wire

[src/btff_datapath.sv]
// tag memory, heap registers and offset arithmetic of the allocator
`default_nettype none
module btff_datapath #(
    parameter int unsigned HEAP_BYTES      = btff_pkg::HEAP_BYTES_DEF,
    parameter int unsigned MIN_SPLIT_BYTES = btff_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  btff_pkg::t_cmd               i_cmd,
    output btff_pkg::t_flags             o_flags,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire  [btff_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire                          i_action,
    input  wire  [15:0]                  i_req,
    input  wire  [15:0]                  i_addr,
    output logic                         o_valid,
    input  wire                          i_out_ready,
    output logic [15:0]                  o_payload_addr,
    output logic [16:0]                  o_granted_bytes,
    output logic [1:0]                   o_status
);
    import btff_pkg::*;

    localparam int unsigned STORE_BYTES = (HEAP_BYTES > 65536) ? 65536 : HEAP_BYTES;
    localparam int unsigned WORDS       = STORE_BYTES / 4;
    localparam int unsigned AW          = $clog2(WORDS);
    localparam logic [OFF_W-1:0] STORE_LIM = OFF_W'(STORE_BYTES);
    localparam logic [OFF_W:0]   SPLIT_ADD = (OFF_W+1)'(MIN_SPLIT_BYTES);

    logic [TAG_W-1:0] r_mem [WORDS];
    logic [TAG_W-1:0] r_rdata;

    logic [CFG_W-1:0] r_limit, r_chunk;
    logic [OFF_W-1:0] r_heap_end, n_heap_end;
    logic             r_ready, n_ready;
    logic             r_action;
    logic [15:0]      r_req, r_addr;
    logic [OFF_W-1:0] r_bp, n_bp, r_s, n_s, r_t, n_t;
    logic [15:0]      r_pay, n_pay;
    logic [16:0]      r_granted, n_granted;
    logic [1:0]       r_status, n_status;
    logic             r_ovalid;

    logic             mem_we, mem_re;
    logic [OFF_W-1:0] mem_off;
    logic [TAG_W-1:0] mem_wd;

    logic [OFF_W-1:0] lim, rdsize, asize, g, bp_prev;
    logic [OFF_W:0]   chunk_r, m_w, g_w;
    logic [OFF_W-1:0] m;

    always_comb begin
        lim     = ({1'b0, r_limit} > {1'b0, STORE_LIM}) ? STORE_LIM : OFF_W'(r_limit);
        chunk_r = ({1'b0, r_chunk} + 18'd7) & ~18'd7;
        g_w     = (chunk_r < {1'b0, MIN_FIRST}) ? {1'b0, MIN_FIRST} : chunk_r;
        g       = g_w[OFF_W-1:0];
        rdsize  = {r_rdata[16:3], 3'b000};
        asize   = OFF_W'(({1'b0, r_req} + 17'd7) & ~17'd7) + 17'd8;
        m_w     = (chunk_r < {1'b0, asize}) ? {1'b0, asize} : chunk_r;
        m       = m_w[OFF_W-1:0];
        bp_prev = r_bp - r_t;
    end

    always_comb begin
        o_flags.is_free    = (r_action == ACT_FREE);
        o_flags.ready      = r_ready;
        o_flags.init_fits  = (g_w <= {1'b0, lim});
        o_flags.req_zero   = (r_req == 16'd0);
        o_flags.addr_zero  = (r_addr == 16'd0);
        o_flags.bp_lt_end  = (r_bp < r_heap_end);
        o_flags.bp_le_addr = (r_bp <= {1'b0, r_addr});
        o_flags.bp_eq_addr = (r_bp == {1'b0, r_addr});
        o_flags.rd_zero    = (rdsize == '0);
        o_flags.rd_used    = r_rdata[0];
        o_flags.rd_fit     = !r_rdata[0] && (rdsize >= asize);
        o_flags.grow_ok    = !(m_w > {1'b0, lim}) && !(r_heap_end > (lim - m));
        o_flags.prev_ok    = (rdsize >= 17'd8) && (rdsize < r_bp);
        o_flags.split      = !({1'b0, rdsize} < ({1'b0, asize} + SPLIT_ADD));
        o_flags.out_busy   = r_ovalid && !i_out_ready;
    end

    always_comb begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_off    = '0;
        mem_wd     = '0;
        n_heap_end = r_heap_end;
        n_ready    = r_ready;
        n_bp       = r_bp;
        n_s        = r_s;
        n_t        = r_t;
        n_pay      = r_pay;
        n_granted  = r_granted;
        n_status   = r_status;
        unique case (i_cmd)
            C_LOAD: begin
                n_bp = FIRST_BP; n_pay = '0; n_granted = '0; n_status = ST_OK;
            end
            C_INIT_W0: begin mem_we = 1'b1; mem_off = PRO_HDR; mem_wd = PRO_TAG; end
            C_INIT_W1: begin mem_we = 1'b1; mem_off = PRO_FTR; mem_wd = PRO_TAG; end
            C_INIT_W2: begin
                mem_we = 1'b1; mem_off = FIRST_HDR; mem_wd = TAG_W'(g - FIRST_BP);
            end
            C_INIT_W3: begin
                mem_we = 1'b1; mem_off = g - 17'd8; mem_wd = TAG_W'(g - FIRST_BP);
            end
            C_INIT_W4: begin
                mem_we = 1'b1; mem_off = g - 17'd4; mem_wd = EPI_TAG;
                n_heap_end = g; n_ready = 1'b1;
            end
            C_RD_HDR: begin mem_re = 1'b1; mem_off = r_bp - 17'd4; end
            C_BP_ADV: n_bp = r_bp + rdsize;
            C_GROW_W0: begin
                n_bp = r_heap_end;
                mem_we = 1'b1; mem_off = r_heap_end - 17'd4; mem_wd = TAG_W'(m);
            end
            C_GROW_W1: begin
                mem_we = 1'b1; mem_off = r_bp + m - 17'd8; mem_wd = TAG_W'(m);
            end
            C_GROW_W2: begin
                n_heap_end = r_heap_end + m;
                mem_we = 1'b1; mem_off = r_heap_end + m - 17'd4; mem_wd = EPI_TAG;
            end
            C_RD_NEXT: begin
                n_s = rdsize; mem_re = 1'b1; mem_off = r_bp + rdsize - 17'd4;
            end
            C_MRG_W0: begin
                n_t = r_s + rdsize;
                mem_we = 1'b1; mem_off = r_bp - 17'd4; mem_wd = TAG_W'(r_s + rdsize);
            end
            C_MRG_W1: begin
                mem_we = 1'b1; mem_off = r_bp + r_t - 17'd8; mem_wd = TAG_W'(r_t);
            end
            C_RD_PFT: begin mem_re = 1'b1; mem_off = r_bp - 17'd8; end
            C_RD_PHDR: begin
                n_t = rdsize; mem_re = 1'b1; mem_off = r_bp - rdsize - 17'd4;
            end
            C_PM: begin
                n_bp = bp_prev; n_s = rdsize;
                mem_re = 1'b1; mem_off = bp_prev + rdsize - 17'd4;
            end
            C_PL_A: begin
                n_s = rdsize; n_granted = rdsize; n_pay = r_bp[15:0];
                mem_we = 1'b1; mem_off = r_bp - 17'd4; mem_wd = {1'b0, rdsize} | EPI_TAG;
            end
            C_PL_B: begin
                mem_we = 1'b1; mem_off = r_bp + r_s - 17'd8; mem_wd = {1'b0, r_s} | EPI_TAG;
            end
            C_PL_SA: begin
                n_s = rdsize; n_granted = asize; n_pay = r_bp[15:0];
                mem_we = 1'b1; mem_off = r_bp - 17'd4; mem_wd = {1'b0, asize} | EPI_TAG;
            end
            C_PL_SB: begin
                mem_we = 1'b1; mem_off = r_bp + asize - 17'd8;
                mem_wd = {1'b0, asize} | EPI_TAG;
            end
            C_PL_SC: begin
                mem_we = 1'b1; mem_off = r_bp + asize - 17'd4;
                mem_wd = TAG_W'(r_s - asize);
            end
            C_PL_SD: begin
                mem_we = 1'b1; mem_off = r_bp + r_s - 17'd8;
                mem_wd = TAG_W'(r_s - asize);
            end
            C_FR_W0: begin
                n_s = rdsize;
                mem_we = 1'b1; mem_off = r_bp - 17'd4; mem_wd = TAG_W'(rdsize);
            end
            C_FR_W1: begin
                mem_we = 1'b1; mem_off = r_bp + r_s - 17'd8; mem_wd = TAG_W'(r_s);
            end
            C_ST1: n_status = ST_IGNORE;
            C_ST2: n_status = ST_NOMEM;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_off[AW+1:2]] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_off[AW+1:2]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= 17'd65536;
            r_chunk    <= 17'd4096;
            r_heap_end <= '0;
            r_ready    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HEAP_LIMIT) r_limit <= i_cfg_data;
                else r_chunk <= i_cfg_data;
            end
            r_heap_end <= n_heap_end;
            r_ready    <= n_ready;
            if (i_cmd == C_EMIT) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LOAD) begin
            r_action <= i_action;
            r_req    <= i_req;
            r_addr   <= i_addr;
        end
        r_bp      <= n_bp;
        r_s       <= n_s;
        r_t       <= n_t;
        r_pay     <= n_pay;
        r_granted <= n_granted;
        r_status  <= n_status;
        if (i_cmd == C_EMIT) begin
            o_payload_addr  <= r_pay;
            o_granted_bytes <= r_granted;
            o_status        <= r_status;
        end
    end

    assign o_valid = r_ovalid;

endmodule
`default_nettype wire

[src/btff_ctrl.sv]
// sequencing state machine of the allocator
`default_nettype none
module btff_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  btff_pkg::t_flags  i_flags,
    output btff_pkg::t_cmd    o_cmd
);
    import btff_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = C_IDLE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = C_LOAD; n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_flags.is_free) begin
                    n_state = (i_flags.addr_zero || !i_flags.ready) ? S_ST1 : S_FR_TEST;
                end else if (!i_flags.ready) begin
                    n_state = i_flags.init_fits ? S_INIT0 : S_ST2;
                end else begin
                    n_state = S_REQ;
                end
            end
            S_INIT0: begin o_cmd = C_INIT_W0; n_state = S_INIT1; end
            S_INIT1: begin o_cmd = C_INIT_W1; n_state = S_INIT2; end
            S_INIT2: begin o_cmd = C_INIT_W2; n_state = S_INIT3; end
            S_INIT3: begin o_cmd = C_INIT_W3; n_state = S_INIT4; end
            S_INIT4: begin o_cmd = C_INIT_W4; n_state = S_REQ; end
            S_REQ: n_state = i_flags.req_zero ? S_ST1 : S_FF_TEST;
            S_FF_TEST: begin
                if (!i_flags.bp_lt_end) begin
                    n_state = S_GROW;
                end else begin
                    o_cmd = C_RD_HDR; n_state = S_FF_CHK;
                end
            end
            S_FF_CHK: begin
                priority if (i_flags.rd_zero) begin
                    n_state = S_GROW;
                end else if (i_flags.rd_fit) begin
                    n_state = S_PL_CHK;
                end else begin
                    o_cmd = C_BP_ADV; n_state = S_FF_TEST;
                end
            end
            S_GROW: begin
                if (!i_flags.grow_ok) begin
                    n_state = S_ST2;
                end else begin
                    o_cmd = C_GROW_W0; n_state = S_GROW1;
                end
            end
            S_GROW1: begin o_cmd = C_GROW_W1; n_state = S_GROW2; end
            S_GROW2: begin o_cmd = C_GROW_W2; n_state = S_CO_RD; end
            S_CO_RD: begin o_cmd = C_RD_HDR; n_state = S_CO_NX; end
            S_CO_NX: begin o_cmd = C_RD_NEXT; n_state = S_CO_N; end
            S_CO_N: begin
                if (!i_flags.rd_used) begin
                    o_cmd = C_MRG_W0; n_state = S_CO_M1;
                end else begin
                    n_state = S_CO_PF;
                end
            end
            S_CO_M1: begin o_cmd = C_MRG_W1; n_state = S_CO_PF; end
            S_CO_PF: begin o_cmd = C_RD_PFT; n_state = S_CO_PC; end
            S_CO_PC: begin
                if (i_flags.prev_ok) begin
                    o_cmd = C_RD_PHDR; n_state = S_CO_PU;
                end else begin
                    n_state = S_CO_END;
                end
            end
            S_CO_PU: begin
                if (!i_flags.rd_used) begin
                    o_cmd = C_PM; n_state = S_CO_PN;
                end else begin
                    n_state = S_CO_END;
                end
            end
            S_CO_PN: begin
                if (!i_flags.rd_used) begin
                    o_cmd = C_MRG_W0; n_state = S_CO_PM1;
                end else begin
                    n_state = S_CO_END;
                end
            end
            S_CO_PM1: begin o_cmd = C_MRG_W1; n_state = S_CO_END; end
            S_CO_END: n_state = i_flags.is_free ? S_EMIT : S_PL_RD;
            S_PL_RD: begin o_cmd = C_RD_HDR; n_state = S_PL_CHK; end
            S_PL_CHK: begin
                if (i_flags.split) begin
                    o_cmd = C_PL_SA; n_state = S_PL_SB;
                end else begin
                    o_cmd = C_PL_A; n_state = S_PL_B;
                end
            end
            S_PL_B:  begin o_cmd = C_PL_B;  n_state = S_EMIT; end
            S_PL_SB: begin o_cmd = C_PL_SB; n_state = S_PL_SC; end
            S_PL_SC: begin o_cmd = C_PL_SC; n_state = S_PL_SD; end
            S_PL_SD: begin o_cmd = C_PL_SD; n_state = S_EMIT; end
            S_FR_TEST: begin
                if (!(i_flags.bp_lt_end && i_flags.bp_le_addr)) begin
                    n_state = S_ST1;
                end else begin
                    o_cmd = C_RD_HDR; n_state = S_FR_CHK;
                end
            end
            S_FR_CHK: begin
                priority if (i_flags.rd_zero) begin
                    n_state = S_ST1;
                end else if (i_flags.bp_eq_addr) begin
                    if (i_flags.rd_used) begin
                        o_cmd = C_FR_W0; n_state = S_FR_W1;
                    end else begin
                        n_state = S_ST1;
                    end
                end else begin
                    o_cmd = C_BP_ADV; n_state = S_FR_TEST;
                end
            end
            S_FR_W1: begin o_cmd = C_FR_W1; n_state = S_CO_RD; end
            S_ST1: begin o_cmd = C_ST1; n_state = S_EMIT; end
            S_ST2: begin o_cmd = C_ST2; n_state = S_EMIT; end
            S_EMIT: begin
                if (!i_flags.out_busy) begin
                    o_cmd = C_EMIT; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[src/boundary_tag_first_fit_allocator.sv]
// top level of the boundary tag first fit heap allocator
// requests enter on the s_axis channel: tuser selects allocate or free, tdata
// carries the request size and the block to free. one result beat per request
// leaves on m_axis with the granted offset, block size and status.
// configuration writes (heap limit, growth step) use the cfg channel, which is
// always ready; the user must write it only while the block is idle (not enforced).
// one request is worked at a time. an allocate may first lay down the first
// heap, then walks the blocks first fit, reading one tag per block visited
// over the single tag memory port; it may then grow the heap and merge, and
// then places the block. a free walks the blocks to the one to free and then
// merges. accept, dispatch and emit take states of their own.
// a finished result sits in an output register; the next request is accepted
// while it waits, and its own result is held back until m_axis_tready takes
// the one before.
// reset clears the heap (no heap laid down) and loads the default registers;
// the tag memory needs no clearing pass.
`default_nettype none
module boundary_tag_first_fit_allocator #(
    parameter int unsigned HEAP_BYTES      = btff_pkg::HEAP_BYTES_DEF,
    parameter int unsigned MIN_SPLIT_BYTES = btff_pkg::MIN_SPLIT_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // request_bytes[15:0], block_addr[31:16]
    input  wire         s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // payload_addr[15:0], granted_bytes[32:16],
                                        // status[34:33], zero[39:35]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [16:0] i_cfg_data
);
    import btff_pkg::*;

    t_cmd        cmd;
    t_flags      flags;
    logic [15:0] pay;
    logic [16:0] granted;
    logic [1:0]  status;

    assign o_cfg_ready = 1'b1;

    btff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    btff_datapath #(
        .HEAP_BYTES      (HEAP_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_flags         (flags),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (s_axis_tuser),
        .i_req           (s_axis_tdata[15:0]),
        .i_addr          (s_axis_tdata[31:16]),
        .o_valid         (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_payload_addr  (pay),
        .o_granted_bytes (granted),
        .o_status        (status)
    );

    assign m_axis_tdata = {5'd0, status, granted, pay};

endmodule
`default_nettype wire

[src/btff_checker.sv]
// port level assertions for the allocator, bound to the top level
`default_nettype none
module btff_port_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[34:33] != 2'd3)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[34:33] != 2'd0 |->
            m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[32:16] == 17'd0)
        else $error("failed request carries an address or size");

    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32:16] != 17'd0 |->
            m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[2:0] == 3'd0
            && m_axis_tdata[18:16] == 3'd0)
        else $error("grant with bad alignment or null address");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config channel not ready");
endmodule

bind boundary_tag_first_fit_allocator btff_port_checker u_btff_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);
`default_nettype wire
